FILE: hw/rtl/sspq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sspq_pkg
// Shared types and constants of the stable sorted priority queue.
// ----------------------------------------------------------------------------
package sspq_pkg;

	localparam int unsigned PRIO_BITS    = 16;
	localparam int unsigned OPCODE_BITS  = 2;
	localparam int unsigned PAYLOAD_PORT = 32;
	localparam int unsigned OCC_BITS     = 5;
	localparam int unsigned IN_BITS      = 56;
	localparam int unsigned OUT_BITS     = 104;

	typedef enum logic [OPCODE_BITS-1:0] {
		OP_ENQ    = 2'd0,
		OP_DEQ    = 2'd1,
		OP_STATUS = 2'd2,
		OP_SPARE  = 2'd3
	} opcode_t;

	typedef logic signed [PRIO_BITS-1:0] prio_t;

	typedef struct packed {
		logic  enq;
		logic  deq;
		prio_t prio;
	} cell_ctl_t;

endpackage : sspq_pkg
`default_nettype wire

FILE: hw/rtl/stable_sorted_priority_queue_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_top
// Bounded min-first priority queue built as a chain of sorting cells.
// ----------------------------------------------------------------------------
// Takes one operation per clock and returns its result through an output
// register; the input stays ready while that register is empty or being
// drained, so the throughput is one transfer per cycle. Every slot of
// the queue is a cell that compares its priority with the incoming one and
// either holds, takes the new entry or shifts toward its neighbor, so an
// enqueue or dequeue completes in a single pass regardless of depth. Entries
// of equal priority leave in arrival order; an enqueue into a full queue is
// dropped and flagged.
module stable_sorted_priority_queue_top
	import sspq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH  = 16,
	parameter int unsigned PAYLOAD_BITS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// opcode, entry_priority, entry_payload, zero fill
	input  wire logic [IN_BITS-1:0]  s_tdata,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// popped_valid, popped_priority, popped_payload, insert_rejected,
	// head_valid, head_priority, head_payload, occupancy
	output logic [OUT_BITS-1:0]      m_tdata
);

	localparam int unsigned STORE_BITS = (PAYLOAD_BITS < PAYLOAD_PORT) ? PAYLOAD_BITS
	                                                                    : PAYLOAD_PORT;
	localparam int unsigned CNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	opcode_t                 op;
	prio_t                   in_prio;
	logic [PAYLOAD_PORT-1:0] in_payload;
	logic                    take;
	logic                    full;
	logic                    empty;
	cell_ctl_t               ctl;

	logic [CNT_BITS-1:0]     count_q;
	logic [CNT_BITS-1:0]     count_d;

	logic                    after_w   [QUEUE_DEPTH];
	logic                    valid_w   [QUEUE_DEPTH];
	prio_t                   prio_w    [QUEUE_DEPTH];
	logic [STORE_BITS-1:0]   payload_w [QUEUE_DEPTH];
	logic                    valid_n   [QUEUE_DEPTH];
	prio_t                   prio_n    [QUEUE_DEPTH];
	logic [STORE_BITS-1:0]   payload_n [QUEUE_DEPTH];

	logic                    popped_valid;
	prio_t                   popped_prio;
	logic [PAYLOAD_PORT-1:0] popped_payload;
	logic                    rejected;
	prio_t                   head_prio;
	logic [PAYLOAD_PORT-1:0] head_payload;
	logic [31:0]             occ_wide;
	logic [OUT_BITS-1:0]     result;
	logic [OUT_BITS-1:0]     m_tdata_q;
	logic                    m_tvalid_q;

	assign op         = opcode_t'(s_tdata[1:0]);
	assign in_prio    = prio_t'(s_tdata[17:2]);
	assign in_payload = s_tdata[49:18];
	assign s_tready   = !m_tvalid_q || m_tready;
	assign take       = s_tvalid && s_tready;
	assign full       = valid_w[QUEUE_DEPTH-1];
	assign empty      = !valid_w[0];

	assign ctl = '{
		enq:  take && (op == OP_ENQ) && !full,
		deq:  take && (op == OP_DEQ) && !empty,
		prio: in_prio
	};

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                  l_after;
		logic                  l_valid;
		prio_t                 l_prio;
		logic [STORE_BITS-1:0] l_payload;
		logic                  r_valid;
		prio_t                 r_prio;
		logic [STORE_BITS-1:0] r_payload;

		if (i == 0) begin : g_first
			assign l_after   = 1'b1;
			assign l_valid   = 1'b0;
			assign l_prio    = '0;
			assign l_payload = '0;
		end else begin : g_mid
			assign l_after   = after_w[i-1];
			assign l_valid   = valid_w[i-1];
			assign l_prio    = prio_w[i-1];
			assign l_payload = payload_w[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign r_valid   = 1'b0;
			assign r_prio    = '0;
			assign r_payload = '0;
		end else begin : g_inner
			assign r_valid   = valid_w[i+1];
			assign r_prio    = prio_w[i+1];
			assign r_payload = payload_w[i+1];
		end

		sspq_cell #(
			.STORE_BITS(STORE_BITS)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.new_payload  (in_payload[STORE_BITS-1:0]),
			.left_after   (l_after),
			.left_valid   (l_valid),
			.left_prio    (l_prio),
			.left_payload (l_payload),
			.right_valid  (r_valid),
			.right_prio   (r_prio),
			.right_payload(r_payload),
			.after        (after_w[i]),
			.valid_q      (valid_w[i]),
			.prio_q       (prio_w[i]),
			.payload_q    (payload_w[i]),
			.valid_d      (valid_n[i]),
			.prio_d       (prio_n[i]),
			.payload_d    (payload_n[i])
		);
	end

	always_comb begin
		count_d = count_q;
		if (ctl.enq) begin
			count_d = count_q + 1'b1;
		end else if (ctl.deq) begin
			count_d = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_comb begin
		popped_valid   = ctl.deq;
		popped_prio    = ctl.deq ? prio_w[0] : '0;
		popped_payload = ctl.deq ? PAYLOAD_PORT'(payload_w[0]) : '0;
		rejected       = take && (op == OP_ENQ) && full;
		head_prio      = valid_n[0] ? prio_n[0] : '0;
		head_payload   = valid_n[0] ? PAYLOAD_PORT'(payload_n[0]) : '0;
		occ_wide       = 32'(count_d);
		result         = '0;
		result[0]      = popped_valid;
		result[16:1]   = popped_prio;
		result[48:17]  = popped_payload;
		result[49]     = rejected;
		result[50]     = valid_n[0];
		result[66:51]  = head_prio;
		result[98:67]  = head_payload;
		result[103:99] = occ_wide[OCC_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			m_tdata_q <= result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule : stable_sorted_priority_queue_top
`default_nettype wire

FILE: hw/rtl/sspq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sspq_cell
// One slot of the sorted chain: keeps, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
module sspq_cell
	import sspq_pkg::*;
#(
	parameter int unsigned STORE_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cell_ctl_t             ctl,
	input  wire logic [STORE_BITS-1:0] new_payload,
	input  wire logic                  left_after,
	input  wire logic                  left_valid,
	input  wire prio_t                 left_prio,
	input  wire logic [STORE_BITS-1:0] left_payload,
	input  wire logic                  right_valid,
	input  wire prio_t                 right_prio,
	input  wire logic [STORE_BITS-1:0] right_payload,
	output logic                       after,
	output logic                       valid_q,
	output prio_t                      prio_q,
	output logic [STORE_BITS-1:0]      payload_q,
	output logic                       valid_d,
	output prio_t                      prio_d,
	output logic [STORE_BITS-1:0]      payload_d
);

	// new entry goes behind this slot
	assign after = valid_q && (prio_q <= ctl.prio);

	always_comb begin
		valid_d   = valid_q;
		prio_d    = prio_q;
		payload_d = payload_q;
		if (ctl.enq && !after) begin
			if (left_after) begin
				valid_d   = 1'b1;
				prio_d    = ctl.prio;
				payload_d = new_payload;
			end else begin
				valid_d   = left_valid;
				prio_d    = left_prio;
				payload_d = left_payload;
			end
		end else if (ctl.deq) begin
			valid_d   = right_valid;
			prio_d    = right_prio;
			payload_d = right_payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		prio_q    <= prio_d;
		payload_q <= payload_d;
	end

endmodule : sspq_cell
`default_nettype wire

FILE: hw/rtl/sspq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sspq_checker
// Port-level checks of the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module sspq_checker
	import sspq_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic [IN_BITS-1:0]  s_tdata,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [OUT_BITS-1:0] m_tdata
);

	// held result does not change
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// input only backs up behind a waiting result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[50] |->
			m_tdata[66:51] == '0 && m_tdata[98:67] == '0 && m_tdata[103:99] == '0)
		else $error("empty queue shows a head or occupancy");

	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[50] |-> m_tdata[103:99] != '0)
		else $error("head present with zero occupancy");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[49]))
		else $error("pop and reject in one result");

endmodule : sspq_checker

bind stable_sorted_priority_queue_top sspq_checker u_sspq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
`default_nettype wire

FILE: tb/sv/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stable sorted priority queue. A local model of
// the sorted slot array predicts every result; each output transfer is
// compared field by field with the oldest prediction. Directed tests cover
// the empty queue, priority extremes, stable ordering of ties and filling
// past full then draining; random traffic then swings the queue between
// full and empty with idle bursts on both stream sides.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sspq_pkg::*;

	localparam int DEPTH      = 16;
	localparam int CYCLE_CAP  = 250000;

	typedef struct packed {
		logic [5:0]  fill;
		logic [31:0] payload;
		prio_t       prio;
		opcode_t     op;
	} op_word_t;

	typedef struct packed {
		logic [4:0]  occupancy;
		logic [31:0] head_payload;
		prio_t       head_priority;
		logic        head_valid;
		logic        insert_rejected;
		logic [31:0] popped_payload;
		prio_t       popped_priority;
		logic        popped_valid;
	} queue_status_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	// opcode, entry_priority, entry_payload, zero fill
	logic [IN_BITS-1:0]  s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// popped_valid, popped_priority, popped_payload, insert_rejected,
	// head_valid, head_priority, head_payload, occupancy
	logic [OUT_BITS-1:0] m_tdata;

	prio_t         slot_prio [DEPTH];
	logic [31:0]   slot_payload [DEPTH];
	int            slot_count = 0;
	queue_status_t pending_status [$];

	bit idle_en = 1'b1;
	int n_errors = 0;
	int n_ops = 0;
	int n_enq = 0;
	int n_rejected = 0;
	int n_deq = 0;
	int n_deq_empty = 0;
	int n_checked = 0;
	int peak_count = 0;
	int cycles = 0;

	stable_sorted_priority_queue_top #(
		.QUEUE_DEPTH (DEPTH),
		.PAYLOAD_BITS(32)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("testbench: errors");
			$finish;
		end
	end

	function automatic queue_status_t queue_step(opcode_t op, prio_t prio,
			logic [31:0] payload);
		queue_status_t r;
		int pos;
		r = '0;
		n_ops++;
		case (op)
			OP_ENQ: begin
				n_enq++;
				if (slot_count >= DEPTH) begin
					r.insert_rejected = 1'b1;
					n_rejected++;
				end else begin
					pos = 0;
					while (pos < slot_count && slot_prio[pos] <= prio)
						pos++;
					for (int i = slot_count; i > pos; i--) begin
						slot_prio[i]    = slot_prio[i-1];
						slot_payload[i] = slot_payload[i-1];
					end
					slot_prio[pos]    = prio;
					slot_payload[pos] = payload;
					slot_count++;
				end
			end
			OP_DEQ: begin
				n_deq++;
				if (slot_count > 0) begin
					r.popped_valid    = 1'b1;
					r.popped_priority = slot_prio[0];
					r.popped_payload  = slot_payload[0];
					for (int i = 0; i + 1 < slot_count; i++) begin
						slot_prio[i]    = slot_prio[i+1];
						slot_payload[i] = slot_payload[i+1];
					end
					slot_count--;
				end else begin
					n_deq_empty++;
				end
			end
			default: ;
		endcase
		if (slot_count > 0) begin
			r.head_valid    = 1'b1;
			r.head_priority = slot_prio[0];
			r.head_payload  = slot_payload[0];
		end
		r.occupancy = slot_count[4:0];
		if (slot_count > peak_count)
			peak_count = slot_count;
		return r;
	endfunction

	task automatic push_op(opcode_t op, prio_t prio, logic [31:0] payload);
		op_word_t w;
		if (idle_en && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= IN_BITS'({$urandom, $urandom});
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		w = '0;
		w.op      = op;
		w.prio    = prio;
		w.payload = payload;
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		do @(posedge clk); while (!s_tready);
		pending_status.push_back(queue_step(op, prio, payload));
	endtask

	always begin
		@(posedge clk);
		if (idle_en && $urandom_range(0, 6) == 0) begin
			m_tready <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		m_tready <= 1'b1;
	end

	task automatic check_field(string name, longint exp_val, longint act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			n_errors++;
		end
	endtask

	always @(posedge clk) begin
		queue_status_t got;
		queue_status_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_status.size() == 0) begin
				$error("result transfer with no prediction pending");
				n_errors++;
			end else begin
				want = pending_status.pop_front();
				n_checked++;
				check_field("popped_valid", want.popped_valid, got.popped_valid);
				check_field("popped_priority", want.popped_priority,
					got.popped_priority);
				check_field("popped_payload", want.popped_payload, got.popped_payload);
				check_field("insert_rejected", want.insert_rejected,
					got.insert_rejected);
				check_field("head_valid", want.head_valid, got.head_valid);
				check_field("head_priority", want.head_priority, got.head_priority);
				check_field("head_payload", want.head_payload, got.head_payload);
				check_field("occupancy", want.occupancy, got.occupancy);
			end
		end
	end

	function automatic prio_t pick_prio();
		case ($urandom_range(0, 9))
			0: return prio_t'(16'sh8000);
			1: return prio_t'(16'sh7fff);
			2, 3, 4: return prio_t'($urandom_range(0, 4)) - prio_t'(2);
			default: return prio_t'($urandom);
		endcase
	endfunction

	task automatic test_empty_queue();
		push_op(OP_DEQ, '0, '0);
		push_op(OP_STATUS, prio_t'(16'sh1234), 32'hdead_beef);
		push_op(OP_SPARE, prio_t'(16'sh8000), 32'hffff_ffff);
	endtask

	task automatic test_priority_extremes();
		push_op(OP_ENQ, prio_t'(16'sh7fff), 32'h0000_0000);
		push_op(OP_ENQ, prio_t'(16'sh8000), 32'hffff_ffff);
		push_op(OP_ENQ, prio_t'(16'sh0000), 32'h5a5a_a5a5);
		push_op(OP_STATUS, '0, '0);
		push_op(OP_SPARE, prio_t'(16'sh7fff), 32'ha5a5_5a5a);
		repeat (3) push_op(OP_DEQ, prio_t'(16'sh7fff), 32'hffff_ffff);
	endtask

	task automatic test_stable_ties();
		push_op(OP_ENQ, prio_t'(5), 32'd1);
		push_op(OP_ENQ, prio_t'(5), 32'd2);
		push_op(OP_ENQ, prio_t'(4), 32'd3);
		push_op(OP_ENQ, prio_t'(5), 32'd4);
		repeat (4) push_op(OP_DEQ, '0, '0);
	endtask

	task automatic test_fill_and_drain();
		repeat (DEPTH + 1) push_op(OP_ENQ, pick_prio(), $urandom);
		push_op(OP_ENQ, pick_prio(), $urandom);
		push_op(OP_STATUS, pick_prio(), $urandom);
		repeat (DEPTH + 1) push_op(OP_DEQ, pick_prio(), $urandom);
	endtask

	task automatic test_random_traffic(int n_items);
		int left;
		int run_len;
		int enq_pct;
		int roll;
		opcode_t op;
		left = n_items;
		while (left > 0) begin
			run_len = $urandom_range(10, 40);
			case ($urandom_range(0, 2))
				0: enq_pct = 80;
				1: enq_pct = 15;
				default: enq_pct = 45;
			endcase
			for (int k = 0; k < run_len && left > 0; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 8)
					op = opcode_t'($urandom_range(2, 3));
				else if (roll < 8 + enq_pct)
					op = OP_ENQ;
				else
					op = OP_DEQ;
				push_op(op, pick_prio(), $urandom);
				left--;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_priority_extremes();
		test_stable_ties();
		test_fill_and_drain();
		test_random_traffic(900);
		idle_en = 1'b0;
		test_random_traffic(150);

		s_tvalid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);

		$display("summary: %0d operations, %0d enqueues (%0d dropped full), %0d dequeues",
			n_ops, n_enq, n_rejected, n_deq);
		$display("summary: %0d dequeues on empty, peak occupancy %0d, %0d results checked",
			n_deq_empty, peak_count, n_checked);
		if (n_errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule : testbench
`default_nettype wire

FILE: sim.f
hw/rtl/sspq_pkg.sv
hw/rtl/sspq_cell.sv
hw/rtl/stable_sorted_priority_queue_top.sv
hw/rtl/sspq_checker.sv
tb/sv/testbench.sv
